>>> hw/rtl/pst_pkg.sv
`default_nettype none

package pst_pkg;

   localparam int MaxResults = 3;

   // token kinds
   localparam logic [4:0] KIND_WORD     = 5'd0;
   localparam logic [4:0] KIND_NUMBER   = 5'd1;
   localparam logic [4:0] KIND_LABEL    = 5'd2;
   localparam logic [4:0] KIND_REGISTER = 5'd3;
   localparam logic [4:0] KIND_INPUT    = 5'd4;
   localparam logic [4:0] KIND_OUTPUT   = 5'd5;
   localparam logic [4:0] KIND_PIPE     = 5'd6;
   localparam logic [4:0] KIND_STRING   = 5'd7;
   localparam logic [4:0] KIND_COMMENT  = 5'd8;
   localparam logic [4:0] KIND_LBRACE   = 5'd9;
   localparam logic [4:0] KIND_RBRACE   = 5'd10;
   localparam logic [4:0] KIND_COLON    = 5'd11;
   localparam logic [4:0] KIND_BAR      = 5'd12;
   localparam logic [4:0] KIND_DOT      = 5'd13;
   localparam logic [4:0] KIND_SEMI     = 5'd14;
   localparam logic [4:0] KIND_COMMA    = 5'd15;
   localparam logic [4:0] KIND_LPAREN   = 5'd16;
   localparam logic [4:0] KIND_RPAREN   = 5'd17;
   localparam logic [4:0] KIND_HASH     = 5'd18;
   localparam logic [4:0] KIND_GT       = 5'd19;
   localparam logic [4:0] KIND_STAR     = 5'd20;
   localparam logic [4:0] KIND_SLASH    = 5'd21;
   localparam logic [4:0] KIND_AT       = 5'd22;
   localparam logic [4:0] KIND_DOLLAR   = 5'd23;
   localparam logic [4:0] KIND_PERCENT  = 5'd24;
   localparam logic [4:0] KIND_TICK     = 5'd25;
   localparam logic [4:0] KIND_ERROR    = 5'd26;
   localparam logic [4:0] KIND_NONE     = 5'd27;

   // characters
   localparam logic [7:0] CHR_LF      = 8'h0A;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_FF      = 8'h0C;
   localparam logic [7:0] CHR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHR_COLON   = 8'h3A;
   localparam logic [7:0] CHR_BAR     = 8'h7C;
   localparam logic [7:0] CHR_DOT     = 8'h2E;
   localparam logic [7:0] CHR_SEMI    = 8'h3B;
   localparam logic [7:0] CHR_COMMA   = 8'h2C;
   localparam logic [7:0] CHR_LPAREN  = 8'h28;
   localparam logic [7:0] CHR_RPAREN  = 8'h29;
   localparam logic [7:0] CHR_HASH    = 8'h23;
   localparam logic [7:0] CHR_GT      = 8'h3E;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_SLASH   = 8'h2F;
   localparam logic [7:0] CHR_AT      = 8'h40;
   localparam logic [7:0] CHR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_TICK    = 8'h60;
   localparam logic [7:0] CHR_QUOTE   = 8'h22;
   localparam logic [7:0] CHR_UNDER   = 8'h5F;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [23:0] start_offset;
      logic [23:0] token_length;
      logic        run_last;
   } rsp_type;

   // all results caused by one input byte
   typedef struct packed {
      rsp_type [MaxResults-1:0] item;
      logic [1:0]               count;
   } bundle_type;

endpackage

`default_nettype wire

>>> hw/rtl/pass_script_tokenizer_unit.sv
`default_nettype none

// channel   dir  handshake            payload
// req_      in   req_valid/req_ready  req_type: byte_value, end_of_text
// rsp_      out  rsp_valid/rsp_ready  rsp_type: token_kind, start_offset, token_length, run_last
//
// One byte is taken per cycle while req_ready is high; its results (one to three) are
// queued as one bundle, and a byte with none queues nothing. Results leave one per cycle
// while rsp_ready is high, from the head of a four-bundle queue; each bundle is registered
// in the queue before its first result is offered.
// Synchronous reset clears the tokenizer state and empties the queue.
// req_ready drops only while the queue is full, so rsp stalls reach the tokenizer
// only once four bundles are waiting.

module pass_script_tokenizer_unit #(
   parameter int OFFSET_BITS      = 24,
   parameter int MAX_COMMENT_NEST = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pst_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pst_pkg::rsp_type       rsp_payload
);
   import pst_pkg::*;

   logic       push_valid, push_ready, head_valid, pop;
   bundle_type push_bundle, head_bundle;

   pst_front #(
      .OFFSET_BITS      (OFFSET_BITS),
      .MAX_COMMENT_NEST (MAX_COMMENT_NEST)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle)
   );

   pst_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle),
      .head_valid  (head_valid),
      .pop         (pop),
      .head_bundle (head_bundle)
   );

   pst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> hw/rtl/pst_front.sv
`default_nettype none

module pst_front #(
   parameter int OFFSET_BITS      = 24,
   parameter int MAX_COMMENT_NEST = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pst_pkg::req_type   req_payload,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output pst_pkg::bundle_type     push_bundle
);
   import pst_pkg::*;

   localparam int OB = OFFSET_BITS;
   localparam int WW = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
   localparam int DW = $clog2(MAX_COMMENT_NEST + 1);

   typedef struct packed {
      logic          valid;
      logic [4:0]    kind;
      logic [OB-1:0] start;
      logic [23:0]   length;
      logic          open_string;
      logic          digit_first;
      logic          space_seen;
   } held_type;

   typedef struct packed {
      held_type held;
      logic     emit;
      rsp_type  res;
   } tok_type;

   function automatic logic [23:0] low24(logic [OB-1:0] v);
      logic [WW-1:0] w;
      w = WW'(v);
      return w[23:0];
   endfunction

   function automatic logic [23:0] sat_len(logic [OB-1:0] v);
      logic [WW-1:0] w;
      w = WW'(v);
      return (w > WW'(24'hFFFFFF)) ? 24'hFFFFFF : w[23:0];
   endfunction

   function automatic logic [OB-1:0] sat_inc(logic [OB-1:0] v);
      return (v == '1) ? v : v + OB'(1);
   endfunction

   function automatic logic [23:0] sat_sum(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

   function automatic logic [4:0] classify(logic [7:0] c);
      logic [4:0] k;
      k = KIND_NONE;
      case (c)
         CHR_LBRACE:  k = KIND_LBRACE;
         CHR_RBRACE:  k = KIND_RBRACE;
         CHR_COLON:   k = KIND_COLON;
         CHR_BAR:     k = KIND_BAR;
         CHR_DOT:     k = KIND_DOT;
         CHR_SEMI:    k = KIND_SEMI;
         CHR_COMMA:   k = KIND_COMMA;
         CHR_LPAREN:  k = KIND_LPAREN;
         CHR_RPAREN:  k = KIND_RPAREN;
         CHR_HASH:    k = KIND_HASH;
         CHR_GT:      k = KIND_GT;
         CHR_STAR:    k = KIND_STAR;
         CHR_SLASH:   k = KIND_SLASH;
         CHR_AT:      k = KIND_AT;
         CHR_DOLLAR:  k = KIND_DOLLAR;
         CHR_PERCENT: k = KIND_PERCENT;
         CHR_TICK:    k = KIND_TICK;
         CHR_QUOTE:   k = KIND_STRING;
         default:     k = KIND_NONE;
      endcase
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A) || c == CHR_UNDER) begin
         k = KIND_WORD;
      end
      return k;
   endfunction

   function automatic rsp_type emit_held(held_type h);
      rsp_type r;
      r.token_kind   = (h.kind == KIND_WORD && h.digit_first) ? KIND_NUMBER : h.kind;
      r.start_offset = low24(h.start);
      r.token_length = h.length;
      r.run_last     = 1'b0;
      return r;
   endfunction

   function automatic tok_type fold_run(held_type h, logic [4:0] kind, logic [OB-1:0] start,
                                        logic [OB-1:0] span, logic digit);
      tok_type     t;
      logic [23:0] l;
      logic        merged;
      t.held = h;
      t.emit = 1'b0;
      t.res  = emit_held(h);
      l      = sat_len(span);
      merged = 1'b0;
      if (h.valid && h.open_string) begin
         if (kind == KIND_STRING) begin
            t.held.open_string = 1'b0;
         end else begin
            t.held.length = sat_sum(h.length, l);
         end
      end else if (kind == KIND_NONE) begin
         t.held.space_seen = 1'b1;
      end else begin
         if ((kind == KIND_WORD || kind == KIND_COLON || kind == KIND_GT) &&
             h.valid && !h.space_seen) begin
            if (h.kind == KIND_BAR && kind == KIND_GT) begin
               t.held.kind   = KIND_PIPE;
               t.held.length = sat_sum(h.length, l);
               merged        = 1'b1;
            end else if (kind == KIND_WORD && (h.kind == KIND_AT || h.kind == KIND_DOLLAR ||
                                               h.kind == KIND_PERCENT)) begin
               t.held.kind   = (h.kind == KIND_AT) ? KIND_REGISTER :
                               (h.kind == KIND_DOLLAR) ? KIND_INPUT : KIND_OUTPUT;
               t.held.length = sat_sum(h.length, l);
               merged        = 1'b1;
            end else if (h.kind == KIND_WORD && kind == KIND_COLON) begin
               t.held.kind = KIND_LABEL;
               merged      = 1'b1;
            end
         end
         if (!merged) begin
            t.emit               = h.valid;
            t.held.valid         = 1'b1;
            t.held.kind          = kind;
            t.held.start         = (kind == KIND_STRING) ? sat_inc(start) : start;
            t.held.length        = (kind == KIND_STRING) ? 24'd0 : l;
            t.held.open_string   = (kind == KIND_STRING);
            t.held.digit_first   = digit;
            t.held.space_seen    = 1'b0;
         end
      end
      return t;
   endfunction

   logic [OB-1:0] offset_ff, offset_in;
   logic [4:0]    run_kind_ff, run_kind_in;
   logic [OB-1:0] run_start_ff, run_start_in;
   logic          run_digit_ff, run_digit_in;
   held_type      held_ff, held_in;
   logic [7:0]    prev_ff, prev_in;
   logic          line_ff, line_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          opening_ff, opening_in;
   logic          closing_ff, closing_in;

   logic       accept;
   bundle_type bundle;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      logic [7:0]    c;
      logic [OB-1:0] pos;
      logic          in_cmt;
      logic [1:0]    n;
      logic [4:0]    k;
      tok_type       t;
      rsp_type       err;

      c          = req_payload.byte_value;
      pos        = offset_ff;
      in_cmt     = line_ff || (depth_ff != '0);
      n          = 2'd0;
      bundle     = '0;
      t          = '0;

      offset_in    = offset_ff;
      run_kind_in  = run_kind_ff;
      run_start_in = run_start_ff;
      run_digit_in = run_digit_ff;
      held_in      = held_ff;
      line_in      = line_ff;
      depth_in     = depth_ff;
      opening_in   = opening_ff;
      closing_in   = closing_ff;

      err.token_kind   = KIND_ERROR;
      err.start_offset = low24(pos);
      err.token_length = 24'd0;
      err.run_last     = 1'b0;

      k = classify(c);

      if (c == CHR_LF || c == CHR_CR || c == CHR_FF) begin
         if (!in_cmt && run_kind_ff != KIND_NONE) begin
            t = fold_run(held_in, run_kind_ff, run_start_ff, pos - run_start_ff,
                         run_digit_ff);
            held_in = t.held;
            if (t.emit) begin
               bundle.item[n] = t.res;
               n = n + 2'd1;
            end
            run_kind_in  = KIND_NONE;
            run_start_in = pos;
         end else begin
            opening_in = 1'b0;
            closing_in = 1'b0;
            line_in    = 1'b0;
         end
      end else if (prev_ff == CHR_SLASH && c == CHR_SLASH) begin
         run_kind_in = KIND_COMMENT;
         line_in     = 1'b1;
      end else if (!closing_ff && c == CHR_STAR &&
                   (prev_ff == CHR_SLASH || prev_ff == CHR_LPAREN)) begin
         run_kind_in = KIND_COMMENT;
         if (depth_ff < DW'(MAX_COMMENT_NEST)) begin
            depth_in = depth_ff + DW'(1);
         end
         opening_in = 1'b1;
      end else if (!opening_ff && prev_ff == CHR_STAR && (c == CHR_SLASH || c == CHR_RPAREN)) begin
         run_kind_in = KIND_COMMENT;
         if (depth_ff == '0) begin
            bundle.item[n] = err;
            n = n + 2'd1;
         end else begin
            depth_in = depth_ff - DW'(1);
            if (depth_ff == DW'(1)) begin
               line_in = 1'b0;
            end
         end
         closing_in = 1'b1;
      end else if (in_cmt) begin
         opening_in = 1'b0;
         closing_in = 1'b0;
      end else if (k != run_kind_ff) begin
         closing_in = 1'b0;
         t = fold_run(held_in, run_kind_ff, run_start_ff, pos - run_start_ff, run_digit_ff);
         held_in = t.held;
         if (t.emit) begin
            bundle.item[n] = t.res;
            n = n + 2'd1;
         end
         run_kind_in  = k;
         run_start_in = pos;
         run_digit_in = (c >= 8'h30 && c <= 8'h39);
      end

      prev_in   = c;
      offset_in = sat_inc(pos);

      if (req_payload.end_of_text) begin
         // flush the open run and the held token, then return to reset
         if (run_kind_in != KIND_NONE) begin
            t = fold_run(held_in, run_kind_in, run_start_in, offset_in - run_start_in,
                         run_digit_in);
            held_in = t.held;
            if (t.emit && n != 2'd3) begin
               bundle.item[n] = t.res;
               n = n + 2'd1;
            end
         end
         if (held_in.valid && n != 2'd3) begin
            bundle.item[n] = emit_held(held_in);
            n = n + 2'd1;
         end
         offset_in    = '0;
         run_kind_in  = KIND_NONE;
         run_start_in = '0;
         run_digit_in = 1'b0;
         held_in      = '0;
         prev_in      = 8'd0;
         line_in      = 1'b0;
         depth_in     = '0;
         opening_in   = 1'b0;
         closing_in   = 1'b0;
      end

      if (n != 2'd0) begin
         bundle.item[n - 2'd1].run_last = 1'b1;
      end
      bundle.count = n;
   end

   assign push_valid  = req_valid && (bundle.count != 2'd0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         run_kind_ff  <= KIND_NONE;
         run_start_ff <= '0;
         run_digit_ff <= 1'b0;
         held_ff      <= '0;
         prev_ff      <= 8'd0;
         line_ff      <= 1'b0;
         depth_ff     <= '0;
         opening_ff   <= 1'b0;
         closing_ff   <= 1'b0;
      end else if (accept) begin
         offset_ff    <= offset_in;
         run_kind_ff  <= run_kind_in;
         run_start_ff <= run_start_in;
         run_digit_ff <= run_digit_in;
         held_ff      <= held_in;
         prev_ff      <= prev_in;
         line_ff      <= line_in;
         depth_ff     <= depth_in;
         opening_ff   <= opening_in;
         closing_ff   <= closing_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pst_queue.sv
`default_nettype none

module pst_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire pst_pkg::bundle_type  push_bundle,
   output logic                      head_valid,
   input  wire logic                 pop,
   output pst_pkg::bundle_type       head_bundle
);
   import pst_pkg::*;

   localparam int Depth = 4;
   localparam int PW    = $clog2(Depth);

   bundle_type    entry_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready  = (fill_ff != (PW + 1)'(Depth));
   assign head_valid  = (fill_ff != '0);
   assign head_bundle = entry_ff[rd_ptr_ff];
   assign do_push     = push_valid && push_ready;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pst_back.sv
`default_nettype none

module pst_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire pst_pkg::bundle_type  head_bundle,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pst_pkg::rsp_type          rsp_payload
);
   import pst_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       transfer, last_item;

   assign rsp_valid   = head_valid;
   assign rsp_payload = head_bundle.item[idx_ff];
   assign transfer    = rsp_valid && rsp_ready;
   assign last_item   = (idx_ff == head_bundle.count - 2'd1);
   // drop the bundle once its last result is transferred
   assign pop         = transfer && last_item;

   always_comb begin
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = last_item ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import pst_pkg::*;

   localparam int MAX_NEST = 15;
   localparam logic [23:0] OFS_TOP = 24'hFF_FFFF;

   typedef struct packed {
      req_type payload;
      logic    hold_off;
   } source_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   source_type source_q[$];
   rsp_type    token_q[$];
   rsp_type    byte_tokens[$];
   int         error_count = 0;
   int         sent_count = 0;
   logic       all_drained = 1'b1;
   logic       calm;
   bit         hold_next = 0;
   bit         deep_nest_done = 0;

   // tokenizer state mirror
   logic [23:0] ofs_now;
   logic [4:0]  run_k;
   logic [23:0] run_at;
   bit          run_num;
   logic [4:0]  hold_k;
   logic [23:0] hold_at;
   logic [23:0] hold_len;
   bit          hold_on, hold_str, hold_num;
   bit          gap_seen;
   logic [7:0]  last_byte;
   bit          in_line_cmt;
   int          nest;
   bit          cmt_open, cmt_close;

   pass_script_tokenizer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign calm = (sent_count >= 150) && (sent_count < 260);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = a + b;
      return s[24] ? OFS_TOP : s[23:0];
   endfunction

   function automatic logic [4:0] byte_class(logic [7:0] c);
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
          c == CHR_UNDER)
         return KIND_WORD;
      case (c)
         CHR_LBRACE:  return KIND_LBRACE;
         CHR_RBRACE:  return KIND_RBRACE;
         CHR_COLON:   return KIND_COLON;
         CHR_BAR:     return KIND_BAR;
         CHR_DOT:     return KIND_DOT;
         CHR_SEMI:    return KIND_SEMI;
         CHR_COMMA:   return KIND_COMMA;
         CHR_LPAREN:  return KIND_LPAREN;
         CHR_RPAREN:  return KIND_RPAREN;
         CHR_HASH:    return KIND_HASH;
         CHR_GT:      return KIND_GT;
         CHR_STAR:    return KIND_STAR;
         CHR_SLASH:   return KIND_SLASH;
         CHR_AT:      return KIND_AT;
         CHR_DOLLAR:  return KIND_DOLLAR;
         CHR_PERCENT: return KIND_PERCENT;
         CHR_TICK:    return KIND_TICK;
         CHR_QUOTE:   return KIND_STRING;
         default:     return KIND_NONE;
      endcase
   endfunction

   task automatic clear_tokenizer();
      ofs_now = '0;
      run_k = KIND_NONE;
      run_at = '0;
      run_num = 0;
      hold_k = KIND_WORD;
      hold_at = '0;
      hold_len = '0;
      hold_on = 0;
      hold_str = 0;
      hold_num = 0;
      gap_seen = 0;
      last_byte = '0;
      in_line_cmt = 0;
      nest = 0;
      cmt_open = 0;
      cmt_close = 0;
   endtask

   task automatic put_token(logic [4:0] kind, logic [23:0] at, logic [23:0] len);
      rsp_type t;
      if (byte_tokens.size() < MaxResults) begin
         t.token_kind = kind;
         t.start_offset = at;
         t.token_length = len;
         t.run_last = 1'b0;
         byte_tokens = {byte_tokens, t};
      end
   endtask

   task automatic put_held();
      put_token((hold_k == KIND_WORD && hold_num) ? KIND_NUMBER : hold_k, hold_at, hold_len);
   endtask

   // finish a raw run: absorb into an open string, merge with the held token, or hold it
   task automatic close_run(logic [4:0] kind, logic [23:0] at, logic [23:0] len, bit num);
      logic [23:0] s, l;
      bit          opens;
      s = at;
      l = len;
      opens = 0;
      if (hold_on && hold_str) begin
         if (kind == KIND_STRING) hold_str = 0;
         else hold_len = add_sat(hold_len, l);
         return;
      end
      if (kind == KIND_NONE) begin
         gap_seen = 1;
         return;
      end
      if (kind == KIND_STRING) begin
         s = add_sat(s, 24'd1);
         l = '0;
         opens = 1;
      end else if ((kind == KIND_WORD || kind == KIND_COLON || kind == KIND_GT) &&
                   hold_on && !gap_seen) begin
         if (hold_k == KIND_BAR && kind == KIND_GT) begin
            hold_k = KIND_PIPE;
            hold_len = add_sat(hold_len, l);
            return;
         end
         if (kind == KIND_WORD &&
             (hold_k == KIND_AT || hold_k == KIND_DOLLAR || hold_k == KIND_PERCENT)) begin
            hold_k = (hold_k == KIND_AT) ? KIND_REGISTER :
                     (hold_k == KIND_DOLLAR) ? KIND_INPUT : KIND_OUTPUT;
            hold_len = add_sat(hold_len, l);
            return;
         end
         if (hold_k == KIND_WORD && kind == KIND_COLON) begin
            hold_k = KIND_LABEL;
            return;
         end
      end
      gap_seen = 0;
      if (hold_on) put_held();
      hold_on = 1;
      hold_k = kind;
      hold_at = s;
      hold_len = l;
      hold_str = opens;
      hold_num = num;
   endtask

   task automatic tokenize_byte(req_type r);
      logic [7:0]  c;
      logic [23:0] pos;
      logic [4:0]  k;
      bit          inc;
      c = r.byte_value;
      pos = ofs_now;
      inc = in_line_cmt || nest > 0;
      byte_tokens.delete();
      if (c == CHR_LF || c == CHR_CR || c == CHR_FF) begin
         if (!inc && run_k != KIND_NONE) begin
            close_run(run_k, run_at, pos - run_at, run_num);
            run_k = KIND_NONE;
            run_at = pos;
         end else begin
            cmt_open = 0;
            cmt_close = 0;
            in_line_cmt = 0;
         end
      end else if (last_byte == CHR_SLASH && c == CHR_SLASH) begin
         run_k = KIND_COMMENT;
         in_line_cmt = 1;
      end else if (!cmt_close && c == CHR_STAR &&
                   (last_byte == CHR_SLASH || last_byte == CHR_LPAREN)) begin
         run_k = KIND_COMMENT;
         if (nest < MAX_NEST) nest++;
         cmt_open = 1;
      end else if (!cmt_open && last_byte == CHR_STAR && (c == CHR_SLASH || c == CHR_RPAREN)) begin
         run_k = KIND_COMMENT;
         if (nest == 0) begin
            put_token(KIND_ERROR, pos, '0);
         end else begin
            nest--;
            if (nest == 0) in_line_cmt = 0;
         end
         cmt_close = 1;
      end else if (inc) begin
         cmt_open = 0;
         cmt_close = 0;
      end else begin
         k = byte_class(c);
         if (k != run_k) begin
            cmt_close = 0;
            close_run(run_k, run_at, pos - run_at, run_num);
            run_k = k;
            run_at = pos;
            run_num = (c >= "0" && c <= "9");
         end
      end
      last_byte = c;
      ofs_now = add_sat(pos, 24'd1);
      if (r.end_of_text) begin
         if (run_k != KIND_NONE) close_run(run_k, run_at, ofs_now - run_at, run_num);
         if (hold_on) put_held();
         clear_tokenizer();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
      token_q = {token_q, byte_tokens};
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(logic [7:0] b, bit eot = 0);
      source_type s;
      s.payload.byte_value = b;
      s.payload.end_of_text = eot;
      s.hold_off = hold_next;
      hold_next = 0;
      source_q = {source_q, s};
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] word_char(bit digit);
      int r;
      r = digit ? $urandom_range(52, 61) : $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return CHR_UNDER;
   endfunction

   function automatic logic [7:0] blank_char();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0, 1:    b = " ";
         2:       b = 8'($urandom_range(128, 255));
         default: b = 8'($urandom_range(0, 31));
      endcase
      if (b == CHR_LF || b == CHR_CR || b == CHR_FF) b = 8'h00;
      return b;
   endfunction

   function automatic logic [7:0] punct_char();
      case ($urandom_range(0, 16))
         0:       return CHR_LBRACE;
         1:       return CHR_RBRACE;
         2:       return CHR_COLON;
         3:       return CHR_BAR;
         4:       return CHR_DOT;
         5:       return CHR_SEMI;
         6:       return CHR_COMMA;
         7:       return CHR_LPAREN;
         8:       return CHR_RPAREN;
         9:       return CHR_HASH;
         10:      return CHR_GT;
         11:      return CHR_STAR;
         12:      return CHR_SLASH;
         13:      return CHR_AT;
         14:      return CHR_DOLLAR;
         15:      return CHR_PERCENT;
         default: return CHR_TICK;
      endcase
   endfunction

   function automatic logic [7:0] line_break();
      case ($urandom_range(0, 2))
         0:       return CHR_LF;
         1:       return CHR_CR;
         default: return CHR_FF;
      endcase
   endfunction

   task automatic add_word();
      int n;
      n = $urandom_range(1, 6);
      add_byte(word_char($urandom_range(0, 3) == 0));
      for (int i = 1; i < n; i++) add_byte(word_char(0));
   endtask

   task automatic add_filler();
      case ($urandom_range(0, 3))
         0: ;
         1: add_byte(word_char(0));
         2: add_byte(blank_char());
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic add_block_comment();
      int depth, closes;
      depth = deep_nest_done ? $urandom_range(1, 3) : MAX_NEST + 2;
      deep_nest_done = 1;
      // an extra close leaves a stray mark behind
      closes = ($urandom_range(0, 5) == 0) ? depth + 1 : depth;
      for (int i = 0; i < depth; i++) begin
         add_byte($urandom_range(0, 1) ? CHR_SLASH : CHR_LPAREN);
         add_byte(CHR_STAR);
         add_filler();
      end
      for (int i = 0; i < closes; i++) begin
         add_byte(CHR_STAR);
         add_byte($urandom_range(0, 1) ? CHR_SLASH : CHR_RPAREN);
         add_filler();
      end
   endtask

   task automatic add_fragment();
      logic [7:0] b;
      int         n;
      case ($urandom_range(0, 11))
         0, 1: add_word();
         2: begin
            case ($urandom_range(0, 2))
               0:       add_byte(CHR_AT);
               1:       add_byte(CHR_DOLLAR);
               default: add_byte(CHR_PERCENT);
            endcase
            add_word();
         end
         3: begin
            add_word();
            add_byte(CHR_COLON);
         end
         4: begin
            if ($urandom_range(0, 3) != 0) add_byte(CHR_BAR);
            if ($urandom_range(0, 3) != 0) add_byte(CHR_GT);
         end
         5: begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : 1;
            repeat (n) add_byte(CHR_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               add_byte(b == CHR_QUOTE ? 8'h27 : b);
            end
            if ($urandom_range(0, 7) != 0) add_byte(CHR_QUOTE);
         end
         6: begin
            add_byte(CHR_SLASH);
            add_byte(CHR_SLASH);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
            add_byte(line_break());
         end
         7: add_block_comment();
         8: add_byte(punct_char());
         9: repeat ($urandom_range(1, 3))
               add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
         10: add_byte(line_break());
         default: begin
            add_byte(CHR_STAR);
            add_byte($urandom_range(0, 1) ? CHR_SLASH : CHR_RPAREN);
         end
      endcase
      if ($urandom_range(0, 1) == 0) add_byte(blank_char());
   endtask

   task automatic add_random_text();
      int stop_at;
      stop_at = source_q.size() + $urandom_range(10, 60);
      while (source_q.size() < stop_at) add_fragment();
      add_byte(8'($urandom_range(0, 255)), 1);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      source_type next_in;
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         sent_count <= 0;
      end else begin
         if (req_valid && req_ready) sent_count <= sent_count + 1;
         if (!req_valid || req_ready) begin
            if (source_q.size() > 0 &&
                !(source_q[0].hold_off && (req_valid || !all_drained)) &&
                (calm || $urandom_range(99) >= 25)) begin
               next_in = source_q.pop_front();
               req_valid <= 1'b1;
               req_payload <= next_in.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 25);
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_tokenizer();
         token_q.delete();
         all_drained <= 1'b1;
      end else begin
         if (req_valid && req_ready) tokenize_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               report_error($sformatf("unexpected token kind %0d at offset %0d",
                                      rsp_payload.token_kind, rsp_payload.start_offset));
            end else begin
               want = token_q.pop_front();
               if (rsp_payload.token_kind !== want.token_kind)
                  report_error($sformatf("token_kind got %0d want %0d",
                                         rsp_payload.token_kind, want.token_kind));
               if (rsp_payload.start_offset !== want.start_offset)
                  report_error($sformatf("start_offset got %0d want %0d",
                                         rsp_payload.start_offset, want.start_offset));
               if (rsp_payload.token_length !== want.token_length)
                  report_error($sformatf("token_length got %0d want %0d",
                                         rsp_payload.token_length, want.token_length));
               if (rsp_payload.run_last !== want.run_last)
                  report_error($sformatf("run_last got %0d want %0d",
                                         rsp_payload.run_last, want.run_last));
            end
         end
         all_drained <= (token_q.size() == 0);
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int directed_count;
      // every punctuation class in a row, then a slash on the final byte
      add_text("{}:|.;,()#>*%$@");
      add_byte(CHR_TICK);
      add_byte(CHR_SLASH, 1);
      // merges, number, quoted string, line comment, paren-star comment, stray close
      add_text("|>@r");
      add_byte(8'h00);
      add_text("$i%o l:9x\"s\"//c");
      add_byte(CHR_LF);
      add_text("(*");
      add_byte(8'hFF);
      add_text("*)*");
      add_byte(CHR_SLASH, 1);
      directed_count = source_q.size();

      // hold off until everything so far has drained
      hold_next = 1;
      while (source_q.size() < directed_count + 340) begin
         if ($urandom_range(0, 7) == 0) hold_next = 1;
         add_random_text();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (source_q.size() > 0 || req_valid) @(posedge clock);
      while (token_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
